>>> src/tmbs_pkg.sv
// Shared types, constants and helpers for the tile map box sweep collision unit.
package tmbs_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int TILE_SIZE = 16;
    localparam int SUBPIX    = 16;

    localparam int COL_AW    = $clog2(MAX_COLS);
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int CELL_W    = $clog2((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 2;
    localparam int TILE_SH   = $clog2(TILE_SIZE);
    localparam int SUB_SH    = $clog2(SUBPIX);
    localparam int CELL_SH   = TILE_SH + SUB_SH;
    localparam int CFG_W     = 7;
    localparam int NW        = CELL_W;
    localparam int AW        = 18 + CELL_SH;

    localparam logic [1:0] NORM_ZERO  = 2'b00;
    localparam logic [1:0] NORM_PLUS  = 2'b01;
    localparam logic [1:0] NORM_MINUS = 2'b11;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                is_query;
        logic                wr_ok;
        logic [5:0]          tile_col;
        logic [5:0]          tile_row;
        logic                tile_solid;
        logic signed [15:0]  box_x;
        logic signed [15:0]  box_y;
        logic [9:0]          box_w;
        logic [9:0]          box_h;
        logic signed [15:0]  target_x;
        logic signed [15:0]  target_y;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISSUE,
        ST_CHECK,
        ST_RESOLVE,
        ST_OUT
    } state_t;

    function automatic logic signed [AW-1:0] clampa(input logic signed [AW-1:0] v,
                                                   input logic signed [AW-1:0] lo,
                                                   input logic signed [AW-1:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [NW-1:0] eff_size(input logic [CFG_W-1:0] v, input int maxv);
        if (v == '0) return NW'(1);
        if (int'(v) > maxv) return NW'(maxv);
        return NW'(v);
    endfunction

endpackage

>>> src/tmbs_front.sv
// Front end: accepts input words, classifies them and queues them for the sequencer.
module tmbs_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [5:0]            s_tile_col,
    input  logic [5:0]            s_tile_row,
    input  logic                  s_tile_solid,
    input  logic signed [15:0]    s_box_x,
    input  logic signed [15:0]    s_box_y,
    input  logic [9:0]            s_box_w,
    input  logic [9:0]            s_box_h,
    input  logic signed [15:0]    s_target_x,
    input  logic signed [15:0]    s_target_y,
    output logic                  q_valid,
    output tmbs_pkg::item_t       q_item,
    input  logic                  q_pop
);
    import tmbs_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    item_t       in_item;
    logic        push;

    always_comb begin
        in_item.is_query   = (s_mode == MODE_QUERY);
        in_item.wr_ok      = (7'(s_tile_col) < 7'(MAX_COLS)) && (7'(s_tile_row) < 7'(MAX_ROWS));
        in_item.tile_col   = s_tile_col;
        in_item.tile_row   = s_tile_row;
        in_item.tile_solid = s_tile_solid;
        in_item.box_x      = s_box_x;
        in_item.box_y      = s_box_y;
        in_item.box_w      = s_box_w;
        in_item.box_h      = s_box_h;
        in_item.target_x   = s_target_x;
        in_item.target_y   = s_target_y;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

>>> src/tmbs_back.sv
// Back end: tile memory, per-axis sweep sequencer and result register.
module tmbs_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [tmbs_pkg::NW-1:0] n_cols,
    input  logic [tmbs_pkg::NW-1:0] n_rows,
    input  logic                  q_valid,
    input  tmbs_pkg::item_t       q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_pos_x,
    output logic signed [15:0]    m_pos_y,
    output logic signed [1:0]     m_normal_x,
    output logic signed [1:0]     m_normal_y,
    output logic                  m_collided
);
    import tmbs_pkg::*;

    // tile store: one row per word, row valid bits stand in for a reset clear
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_ok_reg;

    state_t state_reg, state_next;
    item_t  item_reg;
    logic   axis_reg;            // 0 = x, 1 = y
    logic   plus_reg;
    logic signed [CELL_W-1:0] a_reg, c_reg, c0_reg, c1_reg, end_reg;
    logic signed [15:0] px_reg, py_reg;
    logic [1:0]  nx_reg, ny_reg;
    logic        hit_reg;

    logic signed [15:0] m_pos_x_reg, m_pos_y_reg;
    logic [1:0]  m_nx_reg, m_ny_reg;
    logic        m_coll_reg, m_valid_reg;

    // axis operand select
    logic signed [15:0] pos, tgt, cross_pos;
    logic [9:0]  size, csize;
    logic [NW-1:0] n_al, n_cr;
    logic        plus;
    logic signed [AW-1:0] edge_v, cs_sum, ce_sum, cr_lo, cr_hi;
    logic signed [AW-1:0] start_v, end_v, c0_v, c1_v;
    logic        walk_empty;
    logic        hit_bit, wr_en;
    logic [ROW_AW-1:0] rd_row;
    logic [COL_AW-1:0] rd_col;
    logic signed [AW-1:0] snap_v, maxq;
    logic signed [15:0] snap_pos, res_pos;
    logic        miss_hit;
    logic [1:0]  res_norm;
    logic        axis_done, res_hit, out_load;

    always_comb begin
        if (!axis_reg) begin
            pos = item_reg.box_x;  tgt = item_reg.target_x; size = item_reg.box_w;
            cross_pos = item_reg.box_y; csize = item_reg.box_h;  n_al = n_cols; n_cr = n_rows;
        end else begin
            pos = item_reg.box_y;  tgt = item_reg.target_y; size = item_reg.box_h;
            cross_pos = item_reg.box_x; csize = item_reg.box_w;  n_al = n_rows; n_cr = n_cols;
        end
        plus    = tgt > pos;
        edge_v  = plus ? AW'({size, SUB_SH'(0)}) : '0;
        cs_sum  = (AW'(pos) + edge_v) >>> CELL_SH;
        ce_sum  = ((AW'(tgt) + edge_v) >>> CELL_SH) + (plus ? AW'(1) : -AW'(1));
        cr_lo   = AW'(cross_pos) >>> CELL_SH;
        cr_hi   = (AW'(cross_pos) + $signed(AW'({csize, SUB_SH'(0)})) - AW'(SUBPIX))
                  >>> CELL_SH;
        start_v = clampa(cs_sum, '0, AW'(n_al) - AW'(1));
        end_v   = clampa(ce_sum, -AW'(1), AW'(n_al));
        c0_v    = clampa(cr_lo, '0, AW'(n_cr) - AW'(1));
        c1_v    = clampa(cr_hi, '0, AW'(n_cr) - AW'(1));
        walk_empty = (plus ? (start_v >= end_v) : (start_v <= end_v)) || (c0_v > c1_v);
    end

    // walk cell to tile address
    assign rd_row  = axis_reg ? a_reg[ROW_AW-1:0] : c_reg[ROW_AW-1:0];
    assign rd_col  = axis_reg ? c_reg[COL_AW-1:0] : a_reg[COL_AW-1:0];
    assign hit_bit = rd_ok_reg && rd_data_reg[rd_col];

    // tile face snap and map clamp
    always_comb begin
        if (plus_reg) snap_v = (AW'(a_reg) <<< CELL_SH) - AW'({size, SUB_SH'(0)});
        else          snap_v = (AW'(a_reg) + AW'(1)) <<< CELL_SH;
        if (snap_v > AW'(32767))       snap_pos = 16'sh7fff;
        else if (snap_v < -AW'(32768)) snap_pos = -16'sh8000;
        else                           snap_pos = snap_v[15:0];
        maxq = (AW'(n_al) - AW'(1)) <<< CELL_SH;
        if (maxq > AW'(32767)) maxq = AW'(32767);
        miss_hit = (tgt < 0) || (AW'(tgt) > maxq);
        if (tgt < 0)             res_pos = '0;
        else if (AW'(tgt) > maxq) res_pos = maxq[15:0];
        else                     res_pos = tgt;
    end

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        axis_done  = 1'b0;
        res_hit    = 1'b0;
        res_norm   = NORM_ZERO;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.is_query) state_next = ST_SETUP;
                    else                 wr_en = q_item.wr_ok;
                end
            end
            ST_SETUP: begin
                if (tgt == pos) axis_done = 1'b1;
                else if (walk_empty) state_next = ST_RESOLVE;
                else state_next = ST_ISSUE;
            end
            ST_ISSUE: state_next = ST_CHECK;
            ST_CHECK: begin
                if (hit_bit) begin
                    axis_done = 1'b1;
                    res_hit   = 1'b1;
                    res_norm  = plus_reg ? NORM_MINUS : NORM_PLUS;
                end else if (c_reg == c1_reg && (a_reg + CELL_W'(plus_reg ? 1 : -1)) == end_reg) begin
                    state_next = ST_RESOLVE;
                end else begin
                    state_next = ST_ISSUE;
                end
            end
            ST_RESOLVE: begin
                axis_done = 1'b1;
                res_hit   = miss_hit;
                res_norm  = miss_hit ? (plus_reg ? NORM_MINUS : NORM_PLUS) : NORM_ZERO;
            end
            ST_OUT: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (axis_done) state_next = axis_reg ? ST_OUT : ST_SETUP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // tile memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (row_valid_reg[q_item.tile_row[ROW_AW-1:0]])
                mem[q_item.tile_row[ROW_AW-1:0]][q_item.tile_col[COL_AW-1:0]] <= q_item.tile_solid;
            else
                mem[q_item.tile_row[ROW_AW-1:0]] <=
                    MAX_COLS'(q_item.tile_solid) << q_item.tile_col[COL_AW-1:0];
        end
        rd_data_reg <= mem[rd_row];
        rd_ok_reg   <= row_valid_reg[rd_row];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) row_valid_reg <= '0;
        else if (wr_en) row_valid_reg[q_item.tile_row[ROW_AW-1:0]] <= 1'b1;
    end

    // sweep datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                item_reg <= q_item;
                axis_reg <= 1'b0;
                hit_reg  <= 1'b0;
            end
            ST_SETUP: begin
                plus_reg <= plus;
                a_reg    <= start_v[CELL_W-1:0];
                end_reg  <= end_v[CELL_W-1:0];
                c_reg    <= c0_v[CELL_W-1:0];
                c0_reg   <= c0_v[CELL_W-1:0];
                c1_reg   <= c1_v[CELL_W-1:0];
            end
            ST_CHECK: begin
                if (c_reg == c1_reg) begin
                    c_reg <= c0_reg;
                    a_reg <= a_reg + CELL_W'(plus_reg ? 1 : -1);
                end else begin
                    c_reg <= c_reg + CELL_W'(1);
                end
            end
            default: ;
        endcase
        if (axis_done) begin
            axis_reg <= 1'b1;
            hit_reg  <= hit_reg | res_hit;
            if (!axis_reg) begin
                px_reg <= (state_reg == ST_CHECK) ? snap_pos :
                          (state_reg == ST_RESOLVE) ? res_pos : tgt;
                nx_reg <= res_norm;
            end else begin
                py_reg <= (state_reg == ST_CHECK) ? snap_pos :
                          (state_reg == ST_RESOLVE) ? res_pos : tgt;
                ny_reg <= res_norm;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pos_x_reg <= px_reg;
            m_pos_y_reg <= py_reg;
            m_nx_reg    <= nx_reg;
            m_ny_reg    <= ny_reg;
            m_coll_reg  <= hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)          m_valid_reg <= 1'b0;
        else if (out_load)     m_valid_reg <= 1'b1;
        else if (m_ready)      m_valid_reg <= 1'b0;
    end

    assign m_valid    = m_valid_reg;
    assign m_pos_x    = m_pos_x_reg;
    assign m_pos_y    = m_pos_y_reg;
    assign m_normal_x = m_nx_reg;
    assign m_normal_y = m_ny_reg;
    assign m_collided = m_coll_reg;

endmodule

>>> src/tile_map_box_sweep_collision_unit.sv
// Top level of the tile map box sweep collision unit: config registers, front and back.
// Keeps a 64x64 grid of solid 16x16-pixel tiles and sweeps a box against it, x then y,
// each axis from the original box. A tile write is done by the idle sequencer. A query
// is picked up, then each axis has a setup step; a moved axis then visits tile cells
// (one tile memory read, then its check) and, when no solid cell is met, a resolve step;
// the result is loaded last. The walk stops at the first solid cell, and each cell is
// read from the single-read-port tile memory before its check. A stalled result that
// is still waiting holds the result load. A two-word queue sits between the
// input and the sequencer, and the result register lets the next word start while a
// result waits. Registers: map_width at 0x0, map_height at 0x4, both reset to 64.
module tile_map_box_sweep_collision_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [5:0]         s_tile_col,
    input  logic [5:0]         s_tile_row,
    input  logic               s_tile_solid,
    input  logic signed [15:0] s_box_x,
    input  logic signed [15:0] s_box_y,
    input  logic [9:0]         s_box_w,
    input  logic [9:0]         s_box_h,
    input  logic signed [15:0] s_target_x,
    input  logic signed [15:0] s_target_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_pos_x,
    output logic signed [15:0] m_pos_y,
    output logic signed [1:0]  m_normal_x,
    output logic signed [1:0]  m_normal_y,
    output logic               m_collided
);
    import tmbs_pkg::*;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [CFG_W-1:0] map_width_reg, map_height_reg;
    logic             cfg_wr;
    logic             q_valid, q_pop;
    item_t            q_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= CFG_W'(64);
            map_height_reg <= CFG_W'(64);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) map_width_reg  <= pwdata[CFG_W-1:0];
            else                       map_height_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = 32'(map_width_reg);
            REG_HEIGHT: prdata = 32'(map_height_reg);
            default:    prdata = '0;
        endcase
    end

    tmbs_front u_front (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_mode, .s_tile_col, .s_tile_row, .s_tile_solid,
        .s_box_x, .s_box_y, .s_box_w, .s_box_h, .s_target_x, .s_target_y,
        .q_valid, .q_item, .q_pop
    );

    tmbs_back u_back (
        .aclk, .aresetn,
        .n_cols (eff_size(map_width_reg, MAX_COLS)),
        .n_rows (eff_size(map_height_reg, MAX_ROWS)),
        .q_valid, .q_item, .q_pop,
        .m_valid, .m_ready, .m_pos_x, .m_pos_y, .m_normal_x, .m_normal_y, .m_collided
    );

endmodule

>>> src/tmbs_checker.sv
// Port-level checks for the tile map box sweep collision unit, bound to the top level.
module tmbs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               pready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [1:0]  m_normal_x,
    input logic signed [1:0]  m_normal_y,
    input logic               m_collided
);
    a_rst_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

    a_norm_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_x != 2'b10) && (m_normal_y != 2'b10))
        else $error("bad normal code");

    a_norm_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_collided |-> (m_normal_x == 2'b00) && (m_normal_y == 2'b00))
        else $error("normal set without collision");

endmodule

bind tile_map_box_sweep_collision_unit tmbs_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .pready(pready), .m_valid(m_valid),
    .m_ready(m_ready), .m_normal_x(m_normal_x), .m_normal_y(m_normal_y),
    .m_collided(m_collided)
);
